// ===== rtl/tksd_pkg.sv =====
// Shared types, key codes and byte lookup functions for the terminal key decoder.
`default_nettype none

package tksd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ESC   = 3'd1,
        PH_CSI   = 3'd2,
        PH_SS3   = 3'd3,
        PH_DIGIT = 3'd4,
        PH_SEMI  = 3'd5,
        PH_FIVE  = 3'd6
    } t_phase;

    typedef struct packed {
        logic       emit;
        logic [5:0] key;
        logic [7:0] ch;
    } t_result;

    localparam logic [5:0] KC_UNKNOWN    = 6'd0;
    localparam logic [5:0] KC_ESC        = 6'd1;
    localparam logic [5:0] KC_ENTER      = 6'd2;
    localparam logic [5:0] KC_BACKSPACE  = 6'd3;
    localparam logic [5:0] KC_TAB        = 6'd4;
    localparam logic [5:0] KC_CTRL_A     = 6'd5;
    localparam logic [5:0] KC_CTRL_B     = 6'd6;
    localparam logic [5:0] KC_CTRL_C     = 6'd7;
    localparam logic [5:0] KC_CTRL_D     = 6'd8;
    localparam logic [5:0] KC_CTRL_E     = 6'd9;
    localparam logic [5:0] KC_CTRL_F     = 6'd10;
    localparam logic [5:0] KC_CTRL_K     = 6'd11;
    localparam logic [5:0] KC_CTRL_L     = 6'd12;
    localparam logic [5:0] KC_CTRL_R     = 6'd13;
    localparam logic [5:0] KC_CTRL_T     = 6'd14;
    localparam logic [5:0] KC_CTRL_U     = 6'd15;
    localparam logic [5:0] KC_CTRL_W     = 6'd16;
    localparam logic [5:0] KC_CTRL_Y     = 6'd17;
    localparam logic [5:0] KC_CTRL_Z     = 6'd18;
    localparam logic [5:0] KC_CTRL_BSL   = 6'd19;
    localparam logic [5:0] KC_ALT_B      = 6'd20;
    localparam logic [5:0] KC_ALT_C      = 6'd21;
    localparam logic [5:0] KC_ALT_D      = 6'd22;
    localparam logic [5:0] KC_ALT_F      = 6'd23;
    localparam logic [5:0] KC_ALT_L      = 6'd24;
    localparam logic [5:0] KC_ALT_T      = 6'd25;
    localparam logic [5:0] KC_ALT_U      = 6'd26;
    localparam logic [5:0] KC_ALT_LT     = 6'd27;
    localparam logic [5:0] KC_ALT_GT     = 6'd28;
    localparam logic [5:0] KC_ALT_BKSP   = 6'd29;
    localparam logic [5:0] KC_UP         = 6'd30;
    localparam logic [5:0] KC_DOWN       = 6'd31;
    localparam logic [5:0] KC_RIGHT      = 6'd32;
    localparam logic [5:0] KC_LEFT       = 6'd33;
    localparam logic [5:0] KC_HOME       = 6'd34;
    localparam logic [5:0] KC_END        = 6'd35;
    localparam logic [5:0] KC_DELETE     = 6'd36;
    localparam logic [5:0] KC_PGUP       = 6'd37;
    localparam logic [5:0] KC_PGDN       = 6'd38;
    localparam logic [5:0] KC_CTRL_LEFT  = 6'd39;
    localparam logic [5:0] KC_CTRL_RIGHT = 6'd40;

    localparam logic [7:0] BYTE_ESC   = 8'd27;
    localparam logic [7:0] BYTE_DEL   = 8'd127;
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_TAB   = 8'd9;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_FIVE  = 8'h35;
    localparam logic [7:0] BYTE_LBRK  = 8'h5B;
    localparam logic [7:0] BYTE_UC_O  = 8'h4F;

    function automatic logic [5:0] plain_code(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            BYTE_LF, BYTE_CR:  k = KC_ENTER;
            BYTE_DEL, BYTE_BS: k = KC_BACKSPACE;
            BYTE_TAB:          k = KC_TAB;
            8'd1:              k = KC_CTRL_A;
            8'd2:              k = KC_CTRL_B;
            8'd3:              k = KC_CTRL_C;
            8'd4:              k = KC_CTRL_D;
            8'd5:              k = KC_CTRL_E;
            8'd6:              k = KC_CTRL_F;
            8'd11:             k = KC_CTRL_K;
            8'd12:             k = KC_CTRL_L;
            8'd18:             k = KC_CTRL_R;
            8'd20:             k = KC_CTRL_T;
            8'd21:             k = KC_CTRL_U;
            8'd23:             k = KC_CTRL_W;
            8'd25:             k = KC_CTRL_Y;
            8'd26:             k = KC_CTRL_Z;
            8'd28:             k = KC_CTRL_BSL;
            default:           k = KC_UNKNOWN;
        endcase
        return k;
    endfunction

    // other lowercase letters fall through to unknown
    function automatic logic [5:0] alt_code(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h62:             k = KC_ALT_B;
            8'h63:             k = KC_ALT_C;
            8'h64:             k = KC_ALT_D;
            8'h66:             k = KC_ALT_F;
            8'h6C:             k = KC_ALT_L;
            8'h74:             k = KC_ALT_T;
            8'h75:             k = KC_ALT_U;
            8'h3C:             k = KC_ALT_LT;
            8'h3E:             k = KC_ALT_GT;
            BYTE_DEL, BYTE_BS: k = KC_ALT_BKSP;
            default:           k = KC_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] tilde_code(input logic [7:0] d);
        logic [5:0] k;
        case (d)
            8'h31:   k = KC_HOME;
            8'h33:   k = KC_DELETE;
            8'h34:   k = KC_END;
            8'h35:   k = KC_PGUP;
            8'h36:   k = KC_PGDN;
            default: k = KC_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] csi_code(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h41:   k = KC_UP;
            8'h42:   k = KC_DOWN;
            8'h43:   k = KC_RIGHT;
            8'h44:   k = KC_LEFT;
            8'h48:   k = KC_HOME;
            8'h46:   k = KC_END;
            default: k = KC_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tksd_parser.sv =====
// Escape sequence parser: phase and held digit registers with the decode logic.
`default_nettype none

module tksd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_op,
    input  wire logic [7:0]       i_byte,
    output tksd_pkg::t_result     o_res
);

    tksd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_digit, n_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tksd_pkg::PH_IDLE;
            r_digit <= 8'd0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_digit <= n_digit;
        end
    end

    // next state
    always_comb begin
        n_phase = tksd_pkg::PH_IDLE;
        n_digit = r_digit;
        if (!i_op) begin
            case (r_phase)
                tksd_pkg::PH_IDLE: begin
                    if (i_byte == tksd_pkg::BYTE_ESC) n_phase = tksd_pkg::PH_ESC;
                end
                tksd_pkg::PH_ESC: begin
                    if (i_byte == tksd_pkg::BYTE_LBRK)      n_phase = tksd_pkg::PH_CSI;
                    else if (i_byte == tksd_pkg::BYTE_UC_O) n_phase = tksd_pkg::PH_SS3;
                end
                tksd_pkg::PH_CSI: begin
                    if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
                        n_phase = tksd_pkg::PH_DIGIT;
                        n_digit = i_byte;
                    end
                end
                tksd_pkg::PH_DIGIT: begin
                    if (r_digit == 8'h31 && i_byte == tksd_pkg::BYTE_SEMI)
                        n_phase = tksd_pkg::PH_SEMI;
                end
                tksd_pkg::PH_SEMI: begin
                    if (i_byte == tksd_pkg::BYTE_FIVE) n_phase = tksd_pkg::PH_FIVE;
                end
                default: n_phase = tksd_pkg::PH_IDLE;
            endcase
        end
    end

    // result
    always_comb begin
        o_res.emit = 1'b1;
        o_res.key  = tksd_pkg::KC_UNKNOWN;
        o_res.ch   = 8'd0;
        if (i_op) begin
            if (r_phase != tksd_pkg::PH_IDLE) o_res.key = tksd_pkg::KC_ESC;
        end else begin
            case (r_phase)
                tksd_pkg::PH_ESC: begin
                    if (i_byte == tksd_pkg::BYTE_LBRK || i_byte == tksd_pkg::BYTE_UC_O)
                        o_res.emit = 1'b0;
                    else
                        o_res.key = tksd_pkg::alt_code(i_byte);
                end
                tksd_pkg::PH_CSI: begin
                    if (i_byte >= 8'h30 && i_byte <= 8'h39) o_res.emit = 1'b0;
                    else o_res.key = tksd_pkg::csi_code(i_byte);
                end
                tksd_pkg::PH_SS3: begin
                    if (i_byte == 8'h48)      o_res.key = tksd_pkg::KC_HOME;
                    else if (i_byte == 8'h46) o_res.key = tksd_pkg::KC_END;
                end
                tksd_pkg::PH_DIGIT: begin
                    if (i_byte == tksd_pkg::BYTE_TILDE)
                        o_res.key = tksd_pkg::tilde_code(r_digit);
                    else if (r_digit == 8'h31 && i_byte == tksd_pkg::BYTE_SEMI)
                        o_res.emit = 1'b0;
                end
                tksd_pkg::PH_SEMI: begin
                    if (i_byte == tksd_pkg::BYTE_FIVE) o_res.emit = 1'b0;
                end
                tksd_pkg::PH_FIVE: begin
                    if (i_byte == 8'h44)      o_res.key = tksd_pkg::KC_CTRL_LEFT;
                    else if (i_byte == 8'h43) o_res.key = tksd_pkg::KC_CTRL_RIGHT;
                end
                default: begin
                    // idle
                    if (i_byte == tksd_pkg::BYTE_ESC) begin
                        o_res.emit = 1'b0;
                    end else begin
                        o_res.key = tksd_pkg::plain_code(i_byte);
                        if (o_res.key == tksd_pkg::KC_UNKNOWN) o_res.ch = i_byte;
                    end
                end
            endcase
        end
    end

    a_fail_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_op) |=> (r_phase == tksd_pkg::PH_IDLE))
        else $error("phase not idle after failed read");

    a_fail_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_op) |-> (o_res.emit && o_res.ch == 8'd0))
        else $error("failed read gave no clean result");

    a_silent_opens_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !o_res.emit) |=> (r_phase != tksd_pkg::PH_IDLE))
        else $error("swallowed byte did not advance the sequence");

    a_char_only_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.ch != 8'd0) |-> (o_res.key == tksd_pkg::KC_UNKNOWN
                                && r_phase == tksd_pkg::PH_IDLE))
        else $error("character set outside plain idle byte");

endmodule

`default_nettype wire

// ===== rtl/terminal_key_sequence_decoder.sv =====
// Top level: input stage, sequence parser and result register of the key decoder.
//
//  channel  dir  tdata                               tuser
//  s_axis   in   [7:0] byte_req                      [0] op (1 = no byte)
//  m_axis   out  [5:0] key, [13:6] character, pad 0  -
//
// One item per cycle sustained while the output is not stalled; each item
// passes the input register, then is parsed into the result register. The
// phase/held-digit update is the only loop. Bytes inside a sequence give no
// result. Synchronous active-low reset returns the parser to idle and empties
// both stages. A stalled result holds one item in the input stage before
// s_axis_tready drops.
`default_nettype none

module terminal_key_sequence_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_req
    input  wire logic        s_axis_tuser,   // [0] op
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata    // [5:0] key, [13:6] character, [15:14] zero
);

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [5:0] r_out_key;
    logic [7:0] r_out_ch;

    tksd_pkg::t_result res;
    logic              adv;

    tksd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_op    (r_in_op),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // items with no result move on even while the output is full
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready || !res.emit);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.emit) begin
            r_out_key <= res.key;
            r_out_ch  <= res.ch;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_ch, r_out_key};

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_op)))
        else $error("pending input lost during output stall");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(adv && res.emit))
        else $error("result register overwritten while stalled");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while waiting for ready");

endmodule

`default_nettype wire
